/* rtl/tidtt_pkg.sv */
// Shared types and codes for the tag identifier / type table.
`timescale 1ns / 1ps
`default_nettype none

package tidtt_pkg;

    // Action codes
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_CHANGE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UPDATED = 2'd2;

    // Lookup type codes
    localparam logic [3:0] TYPE_INVALID       = 4'd0;
    localparam logic [3:0] TYPE_UNKNOWN_VALID = 4'd1;

    // Terminator bytes that mark a valid identifier
    localparam logic [7:0] TERM_NUL = 8'd0;
    localparam logic [7:0] TERM_CR  = 8'd13;

    localparam int ID_CHARS = 12;
    localparam int ID_W     = ID_CHARS * 8;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] id_chars_high;
        logic [47:0] id_chars_low;
        logic [7:0]  id_terminator;
        logic [3:0]  new_type;
        logic [3:0]  expected_type;
        logic        accept_unknown;
    } t_in_item;

    typedef struct packed {
        logic [3:0] found_type;
        logic       type_matches;
        logic [1:0] status;
        logic [5:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [3:0]      tag_type;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/tag_id_type_table_top.sv */
// Tag identifier / type table: memory-backed table with linear search.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to TABLE_DEPTH twelve-byte tag identifiers with a 4-bit type each,
// kept in one synchronous single-port-read memory. A lookup or a change-or-add
// walks the filled entries through the memory's read port, one entry per
// cycle, and stops at the first hit; clear, unused actions and lookups with a
// bad terminator skip the walk. One item is worked on at a time; the result
// sits in an output register, so the next item may be taken while that result
// still waits. Change-or-add of a new identifier on a full table reports full
// and leaves the table alone. Reset empties the table at once; no clearing
// pass is needed.
module tag_id_type_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire tidtt_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tidtt_pkg::t_out_item o_out_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state               r_state;
    tidtt_pkg::t_in_item  r_item;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_addr;
    logic                 r_cmp_vld;
    logic [IW-1:0]        r_cmp_idx;
    logic [3:0]           r_res_found;
    logic                 r_res_match;
    logic [1:0]           r_res_status;

    tidtt_pkg::t_entry    r_mem [TABLE_DEPTH];
    tidtt_pkg::t_entry    r_rd_data;

    logic [tidtt_pkg::ID_W-1:0] id_cur;
    logic                 hit;
    logic                 rd_en;
    logic                 search_end;
    logic                 full;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    tidtt_pkg::t_entry    wr_data;
    logic [3:0]           srch_found;
    logic                 in_xfer;
    logic                 out_free;

    function automatic logic type_match(input logic [3:0] found, input logic [3:0] expd,
                                        input logic acc);
        return (found == expd) || (acc && (found == tidtt_pkg::TYPE_UNKNOWN_VALID));
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    always_comb begin
        id_cur     = {r_item.id_chars_high, r_item.id_chars_low};
        hit        = r_cmp_vld && (r_rd_data.id == id_cur);
        rd_en      = (r_state == S_SEARCH) && !hit && (r_addr < r_count);
        search_end = (r_state == S_SEARCH) && (hit || (r_addr == r_count));
        full       = (r_count == CW'(TABLE_DEPTH));
        wr_en      = search_end && (r_item.action == tidtt_pkg::ACT_CHANGE) && (hit || !full);
        wr_addr    = hit ? r_cmp_idx : r_count[IW-1:0];
        wr_data    = '{id: id_cur, tag_type: r_item.new_type};
        srch_found = hit ? r_rd_data.tag_type : tidtt_pkg::TYPE_UNKNOWN_VALID;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_cmp_vld   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_addr    <= '0;
                    r_cmp_vld <= 1'b0;
                    if (in_xfer) begin
                        r_item       <= i_in_data;
                        r_res_found  <= tidtt_pkg::TYPE_INVALID;
                        r_res_match  <= 1'b0;
                        r_res_status <= tidtt_pkg::ST_DONE;
                        r_state      <= S_DONE;
                        case (i_in_data.action)
                            tidtt_pkg::ACT_LOOKUP: begin
                                if (i_in_data.id_terminator == tidtt_pkg::TERM_NUL ||
                                    i_in_data.id_terminator == tidtt_pkg::TERM_CR) begin
                                    r_state <= S_SEARCH;
                                end else begin
                                    r_res_match <= type_match(tidtt_pkg::TYPE_INVALID,
                                                              i_in_data.expected_type,
                                                              i_in_data.accept_unknown);
                                end
                            end
                            tidtt_pkg::ACT_CHANGE: begin
                                r_state <= S_SEARCH;
                            end
                            tidtt_pkg::ACT_CLEAR: begin
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    // Issue one read per cycle; compare the data of the previous read
                    r_cmp_vld <= rd_en;
                    r_cmp_idx <= r_addr[IW-1:0];
                    if (rd_en) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    if (search_end) begin
                        r_state <= S_DONE;
                        if (r_item.action == tidtt_pkg::ACT_LOOKUP) begin
                            r_res_found <= srch_found;
                            r_res_match <= type_match(srch_found, r_item.expected_type,
                                                      r_item.accept_unknown);
                        end else if (hit) begin
                            r_res_status <= tidtt_pkg::ST_UPDATED;
                        end else if (full) begin
                            r_res_status <= tidtt_pkg::ST_FULL;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid             <= 1'b1;
                        o_out_data.found_type   <= r_res_found;
                        o_out_data.type_matches <= r_res_match;
                        o_out_data.status       <= r_res_status;
                        o_out_data.entry_count  <= 6'(r_count);
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
                            r_count == '0))
        else $error("entry count moved by more than one");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_addr < r_count))
        else $error("search read past filled entries");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("second transfer taken while busy");

    a_write_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (search_end && r_item.action == tidtt_pkg::ACT_CHANGE))
        else $error("table written outside change-or-add");
`endif

endmodule

`default_nettype wire
